// ----- src/ogru_pkg.sv -----
// Shared types, constants and codes for the occupancy grid ray update block.
package ogru_pkg;

   localparam int MAP_BITS   = 10;
   localparam int MAP_SIDE   = 1 << MAP_BITS;
   localparam int ADDR_W     = 2 * MAP_BITS;
   localparam int SCORE_W    = 7;
   localparam int COORD_W    = 24;
   localparam int FRAC_BITS  = 8;
   localparam int CPU_W      = 10;
   localparam int DIM_W      = 11;
   localparam int STEP_W     = 5;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 11;

   localparam logic [SCORE_W-1:0] SCORE_UNKNOWN = 7'd50;
   localparam logic [SCORE_W-1:0] SCORE_MAX     = 7'd100;

   localparam logic [1:0] ACT_POSE  = 2'd0;
   localparam logic [1:0] ACT_HIT   = 2'd1;
   localparam logic [1:0] ACT_READ  = 2'd2;
   localparam logic [1:0] ACT_SPARE = 2'd3;

   localparam logic [1:0] STATUS_DONE    = 2'd0;
   localparam logic [1:0] STATUS_OUTSIDE = 2'd1;
   localparam logic [1:0] STATUS_NO_POSE = 2'd2;

   localparam logic [1:0] CLASS_UNKNOWN  = 2'd0;
   localparam logic [1:0] CLASS_FREE     = 2'd1;
   localparam logic [1:0] CLASS_OCCUPIED = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_CELLS_PER_UNIT = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET_X       = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET_Y       = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MAP_WIDTH      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MAP_HEIGHT     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_FREE_STEP      = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_OCCUPIED_STEP  = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE          = 3'd7;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_CONV,
      ST_DECIDE,
      ST_SETUP,
      ST_WALK,
      ST_HIT,
      ST_DRAIN,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic       clear_run;
      logic       accept;
      logic       conv;
      logic       set_pose;
      logic       setup;
      logic       walk;
      logic       hit;
      logic       read;
      logic       res_load;
      logic [1:0] res_status;
      logic       res_read;
      logic       rsp_load;
   } cmd_type;

   typedef struct packed {
      logic       clear_done;
      logic [1:0] action;
      logic       in_map;
      logic       pose_valid;
      logic       walk_last;
      logic       rsp_free;
   } stat_type;

endpackage

// ----- src/ogru_ram.sv -----
// Generic simple dual-port RAM with one write port and a registered read port.
module ogru_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ----- src/ogru_ctrl.sv -----
// Controller state machine that sequences clearing, conversion, line walk and responses.
module ogru_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  ogru_pkg::stat_type stat,
   output ogru_pkg::cmd_type  cmd
);

   ogru_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ogru_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ogru_pkg::ST_CLEAR: begin
            cmd.clear_run = 1'b1;
            if (stat.clear_done) begin
               state_in = ogru_pkg::ST_IDLE;
            end
         end
         ogru_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = ogru_pkg::ST_CONV;
            end
         end
         ogru_pkg::ST_CONV: begin
            cmd.conv = 1'b1;
            state_in = ogru_pkg::ST_DECIDE;
         end
         ogru_pkg::ST_DECIDE: begin
            cmd.res_load   = 1'b1;
            cmd.res_status = ogru_pkg::STATUS_DONE;
            state_in       = ogru_pkg::ST_RESP;
            unique case (stat.action)
               ogru_pkg::ACT_POSE: begin
                  cmd.set_pose = 1'b1;
                  if (!stat.in_map) begin
                     cmd.res_status = ogru_pkg::STATUS_OUTSIDE;
                  end
               end
               ogru_pkg::ACT_HIT: begin
                  if (!stat.pose_valid) begin
                     cmd.res_status = ogru_pkg::STATUS_NO_POSE;
                  end else if (!stat.in_map) begin
                     cmd.res_status = ogru_pkg::STATUS_OUTSIDE;
                  end else begin
                     cmd.res_load = 1'b0;
                     state_in     = ogru_pkg::ST_SETUP;
                  end
               end
               ogru_pkg::ACT_READ: begin
                  if (stat.in_map) begin
                     cmd.read     = 1'b1;
                     cmd.res_read = 1'b1;
                  end else begin
                     cmd.res_status = ogru_pkg::STATUS_OUTSIDE;
                  end
               end
               default: begin
                  cmd.res_status = ogru_pkg::STATUS_DONE;
               end
            endcase
         end
         ogru_pkg::ST_SETUP: begin
            cmd.setup = 1'b1;
            state_in  = ogru_pkg::ST_WALK;
         end
         ogru_pkg::ST_WALK: begin
            cmd.walk = 1'b1;
            if (stat.walk_last) begin
               state_in = ogru_pkg::ST_HIT;
            end
         end
         ogru_pkg::ST_HIT: begin
            cmd.hit  = 1'b1;
            state_in = ogru_pkg::ST_DRAIN;
         end
         ogru_pkg::ST_DRAIN: begin
            cmd.res_load   = 1'b1;
            cmd.res_status = ogru_pkg::STATUS_DONE;
            state_in       = ogru_pkg::ST_RESP;
         end
         ogru_pkg::ST_RESP: begin
            if (stat.rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = ogru_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ogru_pkg::ST_IDLE;
         end
      endcase
   end

   a_no_accept_while_clearing: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ogru_pkg::ST_CLEAR) |-> !req_ready)
      else $error("request taken during clearing pass");

   a_accept_starts_conv: assert property (@(posedge clock) disable iff (reset)
      cmd.accept |=> (state_ff == ogru_pkg::ST_CONV))
      else $error("accepted word did not start conversion");

   a_walk_ends_in_hit: assert property (@(posedge clock) disable iff (reset)
      (cmd.walk && stat.walk_last) |=> cmd.hit)
      else $error("line walk did not end with the hit cell");

endmodule

// ----- src/ogru_dp.sv -----
// Datapath with configuration registers, cell conversion, line walker, score store and result register.
module ogru_dp (
   input  logic                                  clock,
   input  logic                                  reset,
   input  ogru_pkg::cmd_type                     cmd,
   output ogru_pkg::stat_type                    stat,
   input  logic [1:0]                            req_action,
   input  logic signed [ogru_pkg::COORD_W-1:0]   req_coord_x,
   input  logic signed [ogru_pkg::COORD_W-1:0]   req_coord_z,
   input  logic [ogru_pkg::MAP_BITS-1:0]         req_cell_x,
   input  logic [ogru_pkg::MAP_BITS-1:0]         req_cell_y,
   input  logic                                  rsp_ready,
   output logic                                  rsp_valid,
   output logic [1:0]                            rsp_status,
   output logic [ogru_pkg::SCORE_W-1:0]          rsp_cell_value,
   output logic [1:0]                            rsp_cell_class,
   input  logic                                  csr_valid,
   input  logic [ogru_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [ogru_pkg::CSR_DATA_W-1:0]       csr_data
);

   localparam int MB    = ogru_pkg::MAP_BITS;
   localparam int PW    = ogru_pkg::COORD_W + ogru_pkg::CPU_W + 1;
   localparam int QW    = PW - ogru_pkg::FRAC_BITS;
   localparam int CW    = QW + 1;
   localparam int ERR_W = MB + 2;

   logic [ogru_pkg::CPU_W-1:0]         cpu_ff;
   logic [MB-1:0]                      offset_x_ff, offset_y_ff;
   logic [ogru_pkg::DIM_W-1:0]         map_width_ff, map_height_ff;
   logic signed [ogru_pkg::STEP_W-1:0] free_step_ff;
   logic [ogru_pkg::STEP_W-1:0]        occ_step_ff;

   logic [1:0]             action_ff;
   logic [MB-1:0]          cell_x_ff, cell_y_ff;
   logic signed [PW-1:0]   prod_x_ff, prod_z_ff;
   logic [MB-1:0]          col_ff, row_ff;
   logic                   in_map_ff;
   logic [MB-1:0]          sensor_col_ff, sensor_row_ff;
   logic                   sensor_valid_ff;

   logic                   steep_ff, yneg_ff;
   logic [MB-1:0]          x_ff, y_ff, x_end_ff, dx_ff, dy_ff;
   logic signed [ERR_W-1:0] err_ff;

   logic                   wv_ff;
   logic [ogru_pkg::ADDR_W-1:0] waddr_ff;
   logic signed [ogru_pkg::STEP_W:0] step_ff;
   logic [ogru_pkg::ADDR_W-1:0] clr_ff;

   logic [1:0]             res_status_ff;
   logic                   res_read_ff;
   logic                   rsp_valid_ff;
   logic [1:0]             rsp_status_ff, rsp_class_ff;
   logic [ogru_pkg::SCORE_W-1:0] rsp_value_ff;

   logic [ogru_pkg::DIM_W-1:0] w_lim, h_lim;
   logic signed [CW-1:0]   col_full, row_full;
   logic [MB-1:0]          col_sel, row_sel;
   logic                   in_sel;
   logic [MB-1:0]          pc, pr;
   logic                   issue;
   logic [ogru_pkg::ADDR_W-1:0] raddr;
   logic signed [ogru_pkg::STEP_W:0] issue_step;
   logic [ogru_pkg::SCORE_W-1:0] rdata;
   logic signed [ogru_pkg::SCORE_W+1:0] sum;
   logic [ogru_pkg::SCORE_W-1:0] clamped;
   logic                   ram_we;
   logic [ogru_pkg::ADDR_W-1:0] ram_waddr;
   logic [ogru_pkg::SCORE_W-1:0] ram_wdata;
   logic [MB-1:0]          adx, ady, a0, b0, a1, b1, sx0, sy0, sx1, sy1;
   logic                   steep;
   logic signed [ERR_W-1:0] e1;
   logic                   ystep_take;

   function automatic logic signed [CW-1:0] to_cell(input logic signed [PW-1:0] p,
                                                    input logic [MB-1:0] off);
      logic signed [PW-1:0] r;
      begin
         r = p + PW'((1 << ogru_pkg::FRAC_BITS) - 1);
         to_cell = CW'(r >>> ogru_pkg::FRAC_BITS) + CW'($signed({1'b0, off}));
      end
   endfunction

   assign w_lim = (map_width_ff > ogru_pkg::DIM_W'(ogru_pkg::MAP_SIDE))
                  ? ogru_pkg::DIM_W'(ogru_pkg::MAP_SIDE) : map_width_ff;
   assign h_lim = (map_height_ff > ogru_pkg::DIM_W'(ogru_pkg::MAP_SIDE))
                  ? ogru_pkg::DIM_W'(ogru_pkg::MAP_SIDE) : map_height_ff;

   always_comb begin
      col_full = to_cell(prod_x_ff, offset_x_ff);
      row_full = to_cell(prod_z_ff, offset_y_ff);
      if (action_ff == ogru_pkg::ACT_READ) begin
         col_sel = cell_x_ff;
         row_sel = cell_y_ff;
         in_sel  = ({1'b0, cell_x_ff} < w_lim) && ({1'b0, cell_y_ff} < h_lim);
      end else begin
         col_sel = col_full[MB-1:0];
         row_sel = row_full[MB-1:0];
         in_sel  = !col_full[CW-1] && !row_full[CW-1]
                   && (col_full < CW'($signed({1'b0, w_lim})))
                   && (row_full < CW'($signed({1'b0, h_lim})));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cpu_ff        <= 10'd25;
         offset_x_ff   <= 10'd500;
         offset_y_ff   <= 10'd400;
         map_width_ff  <= 11'd900;
         map_height_ff <= 11'd900;
         free_step_ff  <= -5'sd1;
         occ_step_ff   <= 5'd2;
      end else if (csr_valid) begin
         unique case (csr_index)
            ogru_pkg::CSR_CELLS_PER_UNIT: cpu_ff        <= csr_data[9:0];
            ogru_pkg::CSR_OFFSET_X:       offset_x_ff   <= csr_data[9:0];
            ogru_pkg::CSR_OFFSET_Y:       offset_y_ff   <= csr_data[9:0];
            ogru_pkg::CSR_MAP_WIDTH:      map_width_ff  <= csr_data;
            ogru_pkg::CSR_MAP_HEIGHT:     map_height_ff <= csr_data;
            ogru_pkg::CSR_FREE_STEP:      free_step_ff  <= $signed(csr_data[4:0]);
            ogru_pkg::CSR_OCCUPIED_STEP:  occ_step_ff   <= csr_data[4:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         action_ff <= req_action;
         cell_x_ff <= req_cell_x;
         cell_y_ff <= req_cell_y;
         prod_x_ff <= PW'(req_coord_x) * PW'($signed({1'b0, cpu_ff}));
         prod_z_ff <= PW'(req_coord_z) * PW'($signed({1'b0, cpu_ff}));
      end
      if (cmd.conv) begin
         col_ff    <= col_sel;
         row_ff    <= row_sel;
         in_map_ff <= in_sel;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sensor_valid_ff <= 1'b0;
         sensor_col_ff   <= '0;
         sensor_row_ff   <= '0;
      end else if (cmd.set_pose) begin
         sensor_valid_ff <= in_map_ff;
         if (in_map_ff) begin
            sensor_col_ff <= col_ff;
            sensor_row_ff <= row_ff;
         end
      end
   end

   always_comb begin
      adx   = (col_ff > sensor_col_ff) ? col_ff - sensor_col_ff : sensor_col_ff - col_ff;
      ady   = (row_ff > sensor_row_ff) ? row_ff - sensor_row_ff : sensor_row_ff - row_ff;
      steep = ady > adx;
      a0    = steep ? sensor_row_ff : sensor_col_ff;
      b0    = steep ? sensor_col_ff : sensor_row_ff;
      a1    = steep ? row_ff : col_ff;
      b1    = steep ? col_ff : row_ff;
      if (a0 > a1) begin
         sx0 = a1;
         sy0 = b1;
         sx1 = a0;
         sy1 = b0;
      end else begin
         sx0 = a0;
         sy0 = b0;
         sx1 = a1;
         sy1 = b1;
      end
   end

   always_comb begin
      pc         = steep_ff ? y_ff : x_ff;
      pr         = steep_ff ? x_ff : y_ff;
      e1         = err_ff + ERR_W'($signed({1'b0, dy_ff}));
      ystep_take = ($signed({e1, 1'b0}) >= (ERR_W + 1)'($signed({1'b0, dx_ff})));
   end

   always_ff @(posedge clock) begin
      if (cmd.setup) begin
         steep_ff <= steep;
         x_ff     <= sx0;
         y_ff     <= sy0;
         x_end_ff <= sx1;
         dx_ff    <= sx1 - sx0;
         dy_ff    <= (sy1 > sy0) ? sy1 - sy0 : sy0 - sy1;
         yneg_ff  <= !(sy0 < sy1);
         err_ff   <= '0;
      end else if (cmd.walk) begin
         x_ff <= x_ff + 1'b1;
         if (ystep_take) begin
            y_ff   <= yneg_ff ? y_ff - 1'b1 : y_ff + 1'b1;
            err_ff <= e1 - ERR_W'($signed({1'b0, dx_ff}));
         end else begin
            err_ff <= e1;
         end
      end
   end

   always_comb begin
      issue      = 1'b0;
      raddr      = {row_ff, col_ff};
      issue_step = (ogru_pkg::STEP_W + 1)'($signed({1'b0, occ_step_ff}));
      if (cmd.walk) begin
         raddr      = {pr, pc};
         issue_step = (ogru_pkg::STEP_W + 1)'(free_step_ff);
         issue      = !((pc == col_ff) && (pr == row_ff))
                      && ({1'b0, pc} < w_lim) && ({1'b0, pr} < h_lim);
      end else if (cmd.hit) begin
         issue = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wv_ff  <= 1'b0;
         clr_ff <= '0;
      end else begin
         wv_ff <= issue;
         if (cmd.clear_run) begin
            clr_ff <= clr_ff + 1'b1;
         end
      end
      waddr_ff <= raddr;
      step_ff  <= issue_step;
   end

   always_comb begin
      sum = (ogru_pkg::SCORE_W + 2)'($signed({1'b0, rdata})) + (ogru_pkg::SCORE_W + 2)'(step_ff);
      if (sum < 0) begin
         clamped = '0;
      end else if (sum > (ogru_pkg::SCORE_W + 2)'($signed({1'b0, ogru_pkg::SCORE_MAX}))) begin
         clamped = ogru_pkg::SCORE_MAX;
      end else begin
         clamped = sum[ogru_pkg::SCORE_W-1:0];
      end
      ram_we    = cmd.clear_run || wv_ff;
      ram_waddr = cmd.clear_run ? clr_ff : waddr_ff;
      ram_wdata = cmd.clear_run ? ogru_pkg::SCORE_UNKNOWN : clamped;
   end

   ogru_ram #(
      .WIDTH(ogru_pkg::SCORE_W),
      .DEPTH(1 << ogru_pkg::ADDR_W)
   ) u_scores (
      .clock(clock),
      .we   (ram_we),
      .waddr(ram_waddr),
      .wdata(ram_wdata),
      .re   (issue || cmd.read),
      .raddr(raddr),
      .rdata(rdata)
   );

   always_ff @(posedge clock) begin
      if (cmd.res_load) begin
         res_status_ff <= cmd.res_status;
         res_read_ff   <= cmd.res_read;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.rsp_load) begin
         rsp_status_ff <= res_status_ff;
         rsp_value_ff  <= res_read_ff ? rdata : '0;
         if (!res_read_ff || rdata == ogru_pkg::SCORE_UNKNOWN) begin
            rsp_class_ff <= ogru_pkg::CLASS_UNKNOWN;
         end else if (rdata < ogru_pkg::SCORE_UNKNOWN) begin
            rsp_class_ff <= ogru_pkg::CLASS_FREE;
         end else begin
            rsp_class_ff <= ogru_pkg::CLASS_OCCUPIED;
         end
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_cell_value = rsp_value_ff;
   assign rsp_cell_class = rsp_class_ff;

   assign stat.clear_done = &clr_ff;
   assign stat.action     = action_ff;
   assign stat.in_map     = in_map_ff;
   assign stat.pose_valid = sensor_valid_ff;
   assign stat.walk_last  = (x_ff == x_end_ff);
   assign stat.rsp_free   = !rsp_valid_ff || rsp_ready;

endmodule

// ----- src/occupancy_grid_ray_update.sv -----
// Top level of the occupancy grid ray update block.
//
//   channel   direction   ports
//   req       in          req_valid/req_ready, action, coord_x, coord_z, cell_x, cell_y
//   rsp       out         rsp_valid/rsp_ready, status, cell_value, cell_class
//   csr       in          csr_valid/csr_ready, csr_index, csr_data
//
// After reset the score store is swept to 50, one cell a cycle, over all 1048576 cells before
// the first request word is taken; configuration writes are taken at any time.
// A pose, a read or a rejected word passes through conversion and decision to the response.
// For a hit point the line walker steps along the line one cell per cycle, with one
// read-modify-write of the score memory per cell inside the map, the hit cell last.
// A new word is taken while a finished result still waits in the output register.
module occupancy_grid_ray_update (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [1:0]                          req_action,
   input  logic signed [ogru_pkg::COORD_W-1:0] req_coord_x,
   input  logic signed [ogru_pkg::COORD_W-1:0] req_coord_z,
   input  logic [ogru_pkg::MAP_BITS-1:0]       req_cell_x,
   input  logic [ogru_pkg::MAP_BITS-1:0]       req_cell_y,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [1:0]                          rsp_status,
   output logic [ogru_pkg::SCORE_W-1:0]        rsp_cell_value,
   output logic [1:0]                          rsp_cell_class,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [ogru_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [ogru_pkg::CSR_DATA_W-1:0]     csr_data
);

   ogru_pkg::cmd_type  cmd;
   ogru_pkg::stat_type stat;

   assign csr_ready = 1'b1;

   ogru_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .stat     (stat),
      .cmd      (cmd)
   );

   ogru_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .stat          (stat),
      .req_action    (req_action),
      .req_coord_x   (req_coord_x),
      .req_coord_z   (req_coord_z),
      .req_cell_x    (req_cell_x),
      .req_cell_y    (req_cell_y),
      .rsp_ready     (rsp_ready),
      .rsp_valid     (rsp_valid),
      .rsp_status    (rsp_status),
      .rsp_cell_value(rsp_cell_value),
      .rsp_cell_class(rsp_cell_class),
      .csr_valid     (csr_valid),
      .csr_index     (csr_index),
      .csr_data      (csr_data)
   );

endmodule
